// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file icds_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_NOW(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/icds_pkg.sv =====
// Types and constants for the I2C clock divider select block.
// No dependencies.
package icds_pkg;

  localparam int unsigned RATE_W = 22;
  localparam int unsigned KHZ_W = 18;
  localparam int unsigned HZ_W = 28;
  localparam int unsigned DEN_W = 24;
  localparam int unsigned IDEAL_W = 16;
  localparam int unsigned ROM_W = 12;
  localparam int unsigned ACT_W = 24;

  localparam logic [KHZ_W-1:0] KHZ_RESET = 18'd60000;
  localparam logic [KHZ_W-1:0] SHIFT1_LIMIT_KHZ = 18'd50000;
  localparam logic [KHZ_W-1:0] SHIFT2_LIMIT_KHZ = 18'd100000;
  localparam logic [9:0] KHZ_TO_HZ = 10'd1000;
  localparam logic [IDEAL_W-1:0] DIV_MAX = 16'hFFFF;

  localparam logic [5:0] DIV_LAST = 6'd27;
  localparam logic [5:0] ROM_LAST = 6'd63;

  localparam logic [ROM_W-1:0] SCL_ROM [64] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
    12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
    12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
    12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
    12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
    12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
    12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
    12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
  };

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_IDEAL_INIT,
    OP_DIV_STEP,
    OP_SEARCH,
    OP_ACT_INIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] idx;
  } cmd_t;

endpackage

// ===== src/icds_dp.sv =====
// Datapath: bus clock register, shared restoring divider, nearest-entry search.
// Depends on icds_pkg.
module icds_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [icds_pkg::KHZ_W-1:0]     cfg_khz,
  input  logic [icds_pkg::RATE_W-1:0]    target_rate,
  input  icds_pkg::cmd_t                 cmd,
  output logic [1:0]                     prescale_shift,
  output logic [5:0]                     divider_index,
  output logic [icds_pkg::ACT_W-1:0]     actual_rate
);

  logic [icds_pkg::KHZ_W-1:0]   khz;
  logic [icds_pkg::RATE_W-1:0]  rate;
  logic [1:0]                   shift;
  logic [icds_pkg::HZ_W-1:0]    bus_hz;
  logic [icds_pkg::HZ_W-1:0]    dvd;
  logic [icds_pkg::DEN_W-1:0]   dsr;
  logic [icds_pkg::DEN_W-1:0]   rem;
  logic [icds_pkg::HZ_W-1:0]    quo;
  logic [icds_pkg::IDEAL_W-1:0] best_diff;
  logic [5:0]                   best_idx;

  logic [1:0]                   shift_sel;
  logic [icds_pkg::DEN_W:0]     trial;
  logic                         fits;
  logic [icds_pkg::IDEAL_W-1:0] ideal;
  logic [icds_pkg::IDEAL_W-1:0] entry;
  logic [icds_pkg::IDEAL_W-1:0] diff;
  logic [13:0]                  act_den;

  always_comb begin
    if (khz <= icds_pkg::SHIFT1_LIMIT_KHZ) begin
      shift_sel = 2'd0;
    end else if (khz <= icds_pkg::SHIFT2_LIMIT_KHZ) begin
      shift_sel = 2'd1;
    end else begin
      shift_sel = 2'd2;
    end
  end

  assign trial = {rem, dvd[icds_pkg::HZ_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  assign ideal = (quo[icds_pkg::HZ_W-1:icds_pkg::IDEAL_W] != '0) ? icds_pkg::DIV_MAX
               : quo[icds_pkg::IDEAL_W-1:0];
  assign entry = icds_pkg::IDEAL_W'(icds_pkg::SCL_ROM[cmd.idx]);
  assign diff  = (ideal >= entry) ? (ideal - entry) : (entry - ideal);
  assign act_den = 14'(icds_pkg::SCL_ROM[best_idx]) << shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      khz <= icds_pkg::KHZ_RESET;
    end else if (cfg_we) begin
      khz <= cfg_khz;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      icds_pkg::OP_LOAD: begin
        rate   <= target_rate;
        shift  <= shift_sel;
        bus_hz <= icds_pkg::HZ_W'(khz) * icds_pkg::HZ_W'(icds_pkg::KHZ_TO_HZ);
      end
      icds_pkg::OP_IDEAL_INIT: begin
        dvd       <= bus_hz;
        dsr       <= icds_pkg::DEN_W'(rate) << shift;
        rem       <= '0;
        quo       <= '0;
        best_diff <= icds_pkg::DIV_MAX;
        best_idx  <= '0;
      end
      icds_pkg::OP_ACT_INIT: begin
        dvd <= bus_hz;
        dsr <= icds_pkg::DEN_W'(act_den);
        rem <= '0;
        quo <= '0;
      end
      icds_pkg::OP_DIV_STEP: begin
        dvd <= {dvd[icds_pkg::HZ_W-2:0], 1'b0};
        quo <= {quo[icds_pkg::HZ_W-2:0], fits};
        if (fits) begin
          rem <= icds_pkg::DEN_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[icds_pkg::DEN_W-1:0];
        end
      end
      icds_pkg::OP_SEARCH: begin
        if (diff < best_diff) begin
          best_diff <= diff;
          best_idx  <= cmd.idx;
        end
      end
      default: begin
      end
    endcase
  end

  assign prescale_shift = shift;
  assign divider_index  = best_idx;
  assign actual_rate    = quo[icds_pkg::ACT_W-1:0];

endmodule

// ===== src/icds_ctrl.sv =====
// Sequencer: load, ideal divide, table search, actual-rate divide, result strobe.
// Depends on icds_pkg.
module icds_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output icds_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_DIV1   = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_PREP2  = 7'b0010000,
    S_DIV2   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = icds_pkg::OP_NONE;
    cmd.idx    = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = icds_pkg::OP_LOAD;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op     = icds_pkg::OP_IDEAL_INIT;
        cnt_next   = '0;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.op   = icds_pkg::OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == icds_pkg::DIV_LAST) begin
          cnt_next   = icds_pkg::ROM_LAST;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.op   = icds_pkg::OP_SEARCH;
        cnt_next = cnt - 6'd1;
        if (cnt == '0) begin
          state_next = S_PREP2;
        end
      end
      S_PREP2: begin
        cmd.op     = icds_pkg::OP_ACT_INIT;
        cnt_next   = '0;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd.op   = icds_pkg::OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == icds_pkg::DIV_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

endmodule

// ===== src/i2c_clock_divider_select.sv =====
// I2C clock divider select, top level. Depends on icds_pkg, icds_ctrl, icds_dp.
// Sequence: after start is taken, busy stays high until done pulses; a new word is
// taken only while busy is low. A run is two 28-step one-bit-per-cycle
// divisions on the shared divider plus a 64-step walk of the divider table.
// Reset (sync, active high): idle, bus_clock_khz back to 60000.
module i2c_clock_divider_select (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bus_clock_khz_we,
  input  logic [icds_pkg::KHZ_W-1:0]    bus_clock_khz,
  input  logic                          start,
  output logic                          busy,
  input  logic [icds_pkg::RATE_W-1:0]   target_rate,
  output logic                          done,
  output logic [1:0]                    prescale_shift,
  output logic [5:0]                    divider_index,
  output logic [icds_pkg::ACT_W-1:0]    actual_rate
);

  icds_pkg::cmd_t cmd;

  icds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  icds_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (bus_clock_khz_we),
    .cfg_khz        (bus_clock_khz),
    .target_rate    (target_rate),
    .cmd            (cmd),
    .prescale_shift (prescale_shift),
    .divider_index  (divider_index),
    .actual_rate    (actual_rate)
  );

endmodule

// ===== src/icds_checker.sv =====
// Port-level checks for the I2C clock divider select block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module icds_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] prescale_shift
);

  `AST_NOW(a_done_busy, clk, rst, done, busy)
  `AST_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `AST_NEXT(a_done_idle, clk, rst, done, !busy && !done)
  `AST_NOW(a_shift_ok, clk, rst, done, prescale_shift != 2'd3)

endmodule

bind i2c_clock_divider_select icds_checker u_icds_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .prescale_shift (prescale_shift)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for i2c_clock_divider_select: queue-fed driver, done-strobe
// monitor and an in-bench divider predictor over several bus clock settings.
// Depends on icds_pkg and the i2c_clock_divider_select RTL.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned PHASE_WORDS = 111;
  localparam logic [icds_pkg::RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic [1:0]                 shift;
    logic [5:0]                 idx;
    logic [icds_pkg::ACT_W-1:0] actual;
  } divider_choice_t;

  typedef struct {
    bit                          is_write;
    logic [icds_pkg::KHZ_W-1:0]  khz;
    logic [icds_pkg::RATE_W-1:0] rate;
  } pending_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic bus_clock_khz_we = 1'b0;
  logic [icds_pkg::KHZ_W-1:0] bus_clock_khz = '0;
  logic start = 1'b0;
  logic [icds_pkg::RATE_W-1:0] target_rate = '0;
  logic busy;
  logic done;
  logic [1:0] prescale_shift;
  logic [5:0] divider_index;
  logic [icds_pkg::ACT_W-1:0] actual_rate;

  pending_word_t pending_words[$];
  divider_choice_t predicted_choices[$];
  logic [icds_pkg::KHZ_W-1:0] model_khz = icds_pkg::KHZ_RESET;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  i2c_clock_divider_select u_top (
    .clk              (clk),
    .rst              (rst),
    .bus_clock_khz_we (bus_clock_khz_we),
    .bus_clock_khz    (bus_clock_khz),
    .start            (start),
    .busy             (busy),
    .target_rate      (target_rate),
    .done             (done),
    .prescale_shift   (prescale_shift),
    .divider_index    (divider_index),
    .actual_rate      (actual_rate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] shift_for(input logic [icds_pkg::KHZ_W-1:0] khz);
    if (khz <= icds_pkg::SHIFT1_LIMIT_KHZ) return 2'd0;
    if (khz <= icds_pkg::SHIFT2_LIMIT_KHZ) return 2'd1;
    return 2'd2;
  endfunction

  function automatic divider_choice_t select_divider(
      input logic [icds_pkg::KHZ_W-1:0] khz,
      input logic [icds_pkg::RATE_W-1:0] rate);
    divider_choice_t res;
    logic [63:0] hz, denom, ideal, entry, delta, best_delta;
    int i;
    res.shift = shift_for(khz);
    hz = 64'(khz) * 64'd1000;
    denom = 64'(rate) << res.shift;
    if (denom == 0) begin
      ideal = 64'(icds_pkg::DIV_MAX);
    end else begin
      ideal = hz / denom;
      if (ideal > 64'(icds_pkg::DIV_MAX)) ideal = 64'(icds_pkg::DIV_MAX);
    end
    best_delta = 64'(icds_pkg::DIV_MAX);
    res.idx = '0;
    for (i = 63; i >= 0; i--) begin
      entry = 64'(icds_pkg::SCL_ROM[i]);
      delta = (ideal >= entry) ? ideal - entry : entry - ideal;
      if (delta == 0) begin
        res.idx = 6'(i);
        break;
      end
      if (delta < best_delta) begin
        res.idx = 6'(i);
        best_delta = delta;
      end
    end
    res.actual = icds_pkg::ACT_W'(hz / (64'(icds_pkg::SCL_ROM[res.idx]) << res.shift));
    return res;
  endfunction

  function automatic logic [icds_pkg::RATE_W-1:0] pick_rate(
      input logic [icds_pkg::KHZ_W-1:0] khz);
    logic [63:0] r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      r = 64'($urandom_range(0, int'(RATE_MAX)));
    end else if (mode == 2) begin
      r = 64'($urandom_range(0, 2000));
    end else if (mode < 6) begin
      // land on or next to a table entry
      r = (64'(khz) * 64'd1000) /
          (64'(icds_pkg::SCL_ROM[$urandom_range(0, 63)]) << shift_for(khz));
      r = r + 64'($urandom_range(0, 2)) - 64'd1;
      if (r[63]) r = '0;
    end else begin
      r = 64'($urandom_range(1000, 4000000) >> $urandom_range(0, 10));
    end
    if (r > 64'(RATE_MAX)) r = 64'(RATE_MAX);
    return icds_pkg::RATE_W'(r);
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic took, nxt_start, nxt_we;
    logic [icds_pkg::KHZ_W-1:0] nxt_khz;
    logic [icds_pkg::RATE_W-1:0] nxt_rate;
    pending_word_t head;
    if (rst) begin
      start <= 1'b0;
      bus_clock_khz_we <= 1'b0;
      bus_clock_khz <= '0;
      target_rate <= '0;
    end else begin
      took = start && !busy;
      nxt_start = start && !took;
      nxt_we = 1'b0;
      nxt_khz = bus_clock_khz;
      nxt_rate = target_rate;
      if (took) predicted_choices.push_back(select_divider(model_khz, target_rate));
      if (bus_clock_khz_we) model_khz = bus_clock_khz;
      if (!busy && !start && !bus_clock_khz_we && predicted_choices.size() == 0)
        idle_cycles++;
      else
        idle_cycles = 0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          head = pending_words[0];
          if (head.is_write) begin
            if (idle_cycles >= 3) begin
              void'(pending_words.pop_front());
              nxt_we = 1'b1;
              nxt_khz = head.khz;
            end
          end else begin
            void'(pending_words.pop_front());
            nxt_start = 1'b1;
            nxt_rate = head.rate;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 24);
              case ($urandom_range(0, 9))
                0, 1, 2, 3: gap_left = 0;
                4, 5, 6, 7: gap_left = $urandom_range(1, 8);
                8: gap_left = $urandom_range(9, 130);
                default: gap_left = $urandom_range(100, 260);
              endcase
            end
          end
        end
      end
      start <= nxt_start;
      bus_clock_khz_we <= nxt_we;
      bus_clock_khz <= nxt_khz;
      target_rate <= nxt_rate;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    divider_choice_t want;
    if (!rst && done) begin
      if (predicted_choices.size() == 0) begin
        $display("%0t: result word with none expected: shift %0d index %0d rate %0d",
                 $time, prescale_shift, divider_index, actual_rate);
        fault_count++;
      end else begin
        want = predicted_choices.pop_front();
        check_field("prescale_shift", 24'(want.shift), 24'(prescale_shift));
        check_field("divider_index", 24'(want.idx), 24'(divider_index));
        check_field("actual_rate", want.actual, actual_rate);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [icds_pkg::RATE_W-1:0] directed_rates[14];
    logic [icds_pkg::KHZ_W-1:0] settings[12];
    logic [icds_pkg::KHZ_W-1:0] khz;
    pending_word_t w;
    int p, n;
    // reset setting of 60000 kHz: zero rate, overflow, ties, exact and repeated entries
    directed_rates = '{22'd0, 22'd1, 22'd1000, 22'd100000, 22'd400000, 22'd1428571,
                       22'd1500000, 22'd750000, 22'd23437, 22'd7812, 22'd3400000,
                       22'd4000000, RATE_MAX, 22'd2097152};
    settings = '{18'd1000, 18'd50000, 18'd50001, 18'd100000, 18'd100001, 18'd200000,
                 18'd0, 18'h3FFFF, 18'd0, 18'd0, 18'd0, 18'd0};
    settings[8] = icds_pkg::KHZ_W'($urandom_range(1000, 200000));
    settings[9] = icds_pkg::KHZ_W'($urandom_range(1000, 200000));
    settings[10] = icds_pkg::KHZ_W'($urandom_range(0, 262143));
    settings[11] = icds_pkg::KHZ_RESET;
    foreach (directed_rates[i]) begin
      w.is_write = 1'b0;
      w.khz = '0;
      w.rate = directed_rates[i];
      pending_words.push_back(w);
    end
    for (p = 0; p < 12; p++) begin
      khz = settings[p];
      w.is_write = 1'b1;
      w.khz = khz;
      w.rate = '0;
      pending_words.push_back(w);
      for (n = 0; n < PHASE_WORDS; n++) begin
        w.is_write = 1'b0;
        w.rate = pick_rate(khz);
        pending_words.push_back(w);
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0 || start || predicted_choices.size() != 0)
      @(posedge clk);
    repeat (130) @(posedge clk);
    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
